@@ hdl/chs_pkg.sv @@
// Shared constants, types and helpers of the chamfer humidity spread unit.
`default_nettype none
package chs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int CNT_W      = $clog2(CELLS + 1);
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int VAL_W  = 16;
  localparam int SIZE_W = 9;

  localparam logic [VAL_W-1:0] ONE_Q15 = 16'd32768;

  localparam logic [SIZE_W-1:0] RST_WIDTH    = 9'd64;
  localparam logic [SIZE_W-1:0] RST_HEIGHT   = 9'd64;
  localparam logic [VAL_W-1:0]  RST_STRAIGHT = 16'd3277;
  localparam logic [VAL_W-1:0]  RST_DIAGONAL = 16'd4634;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_STRAIGHT = 2'd2;
  localparam logic [1:0] REG_DIAGONAL = 2'd3;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [CNT_W-1:0] cells;
    logic [VAL_W-1:0] s_drop;
    logic [VAL_W-1:0] d_drop;
  } chs_geom_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
  } chs_mem_req_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [SIZE_W-1:0] v, int hi);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > hi) begin
      res = DIM_W'(hi);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hdl/chs_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module chs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/chs_sweep.sv @@
// Sequencer and datapath of the forward and backward chamfer passes over the grid memory.
`default_nettype none
module chs_sweep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire chs_pkg::chs_geom_t           geom,
  input  wire logic [chs_pkg::VAL_W-1:0]    rdata,
  output chs_pkg::chs_mem_req_t             req,
  output logic                              busy
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RS   = 3'd1;
  localparam logic [2:0] S_P0   = 3'd2;
  localparam logic [2:0] S_P1   = 3'd3;
  localparam logic [2:0] S_DR   = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic                        bwd_r, bwd_nxt;
  logic [chs_pkg::ADDR_W-1:0]  a_r, a_nxt;
  logic [chs_pkg::DIM_W-1:0]   k_r, k_nxt;
  logic [chs_pkg::DIM_W-1:0]   r_r, r_nxt;
  logic [chs_pkg::VAL_W-1:0]   self_r, self_nxt;
  logic [chs_pkg::VAL_W-1:0]   up_r, up_nxt;
  logic [chs_pkg::VAL_W-1:0]   ul_r, ul_nxt;
  logic [chs_pkg::VAL_W-1:0]   left_r, left_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [chs_pkg::ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic                        pf_prev_r, pf_prev_nxt;
  logic                        pf_vert_r, pf_vert_nxt;
  logic                        pf_td_r, pf_td_nxt;
  logic                        pf_ad_r, pf_ad_nxt;

  logic [chs_pkg::ADDR_W-1:0]  w_a;
  logic [chs_pkg::ADDR_W-1:0]  vert_addr;
  logic [chs_pkg::ADDR_W-1:0]  ahead_addr;
  logic                        last_col;
  logic                        last_row;
  logic                        first_row;
  logic [chs_pkg::VAL_W-1:0]   c_prev, c_vert, c_td, c_ad, m1, m2, m3, best;

  function automatic logic [chs_pkg::VAL_W-1:0] sat_sub(
    logic [chs_pkg::VAL_W-1:0] a, logic [chs_pkg::VAL_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [chs_pkg::VAL_W-1:0] max2(
    logic [chs_pkg::VAL_W-1:0] a, logic [chs_pkg::VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  assign w_a        = chs_pkg::ADDR_W'(geom.w);
  assign vert_addr  = bwd_r ? (a_r + w_a) : (a_r - w_a);
  assign ahead_addr = bwd_r ? (a_r + w_a - chs_pkg::ADDR_W'(1))
                            : (a_r - w_a + chs_pkg::ADDR_W'(1));
  assign last_col   = (k_r == (geom.w - chs_pkg::DIM_W'(1)));
  assign last_row   = (r_r == (geom.h - chs_pkg::DIM_W'(1)));
  assign first_row  = (r_r == '0);

  assign c_prev = pf_prev_r ? sat_sub(left_r, geom.s_drop) : '0;
  assign c_vert = pf_vert_r ? sat_sub(up_r, geom.s_drop)   : '0;
  assign c_td   = pf_td_r   ? sat_sub(ul_r, geom.d_drop)   : '0;
  assign c_ad   = pf_ad_r   ? sat_sub(rdata, geom.d_drop)  : '0;
  assign m1     = max2(self_r, c_prev);
  assign m2     = max2(c_vert, c_td);
  assign m3     = max2(m1, m2);
  assign best   = max2(m3, c_ad);

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    bwd_nxt       = bwd_r;
    a_nxt         = a_r;
    k_nxt         = k_r;
    r_nxt         = r_r;
    self_nxt      = self_r;
    up_nxt        = up_r;
    ul_nxt        = ul_r;
    left_nxt      = left_r;
    pend_v_nxt    = pend_v_r;
    pend_addr_nxt = pend_addr_r;
    pf_prev_nxt   = pf_prev_r;
    pf_vert_nxt   = pf_vert_r;
    pf_td_nxt     = pf_td_r;
    pf_ad_nxt     = pf_ad_r;
    req           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          bwd_nxt   = 1'b0;
          a_nxt     = '0;
          k_nxt     = '0;
          r_nxt     = '0;
          state_nxt = S_RS;
        end
      end
      S_RS: begin
        req.re     = 1'b1;
        req.raddr  = vert_addr;
        pend_v_nxt = 1'b0;
        state_nxt  = S_P0;
      end
      S_P0: begin
        req.re    = 1'b1;
        req.raddr = a_r;
        if (pend_v_r) begin
          req.we    = 1'b1;
          req.waddr = pend_addr_r;
          req.wdata = best;
          left_nxt  = best;
        end
        up_nxt    = rdata;
        ul_nxt    = up_r;
        state_nxt = S_P1;
      end
      S_P1: begin
        req.re        = 1'b1;
        req.raddr     = ahead_addr;
        self_nxt      = rdata;
        pf_prev_nxt   = (k_r != '0);
        pf_vert_nxt   = !first_row;
        pf_td_nxt     = (k_r != '0) && !first_row;
        pf_ad_nxt     = !last_col && !first_row;
        pend_addr_nxt = a_r;
        pend_v_nxt    = 1'b1;
        a_nxt         = bwd_r ? (a_r - chs_pkg::ADDR_W'(1)) : (a_r + chs_pkg::ADDR_W'(1));
        if (last_col) begin
          state_nxt = S_DR;
        end else begin
          k_nxt     = k_r + chs_pkg::DIM_W'(1);
          state_nxt = S_P0;
        end
      end
      S_DR: begin
        req.we     = 1'b1;
        req.waddr  = pend_addr_r;
        req.wdata  = best;
        k_nxt      = '0;
        pend_v_nxt = 1'b0;
        if (last_row) begin
          if (bwd_r) begin
            state_nxt = S_IDLE;
          end else begin
            bwd_nxt   = 1'b1;
            a_nxt     = chs_pkg::ADDR_W'(geom.cells - chs_pkg::CNT_W'(1));
            r_nxt     = '0;
            state_nxt = S_RS;
          end
        end else begin
          r_nxt     = r_r + chs_pkg::DIM_W'(1);
          state_nxt = S_RS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bwd_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      bwd_r    <= bwd_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    k_r         <= k_nxt;
    r_r         <= r_nxt;
    self_r      <= self_nxt;
    up_r        <= up_nxt;
    ul_r        <= ul_nxt;
    left_r      <= left_nxt;
    pend_addr_r <= pend_addr_nxt;
    pf_prev_r   <= pf_prev_nxt;
    pf_vert_r   <= pf_vert_nxt;
    pf_td_r     <= pf_td_nxt;
    pf_ad_r     <= pf_ad_nxt;
  end

  a_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && req.we && req.re) |-> (req.waddr != req.raddr))
    else $error("sweep reads and writes the same cell in one cycle");

  a_write_captured: assert property (@(posedge clk) disable iff (!rst_n)
    req.we |-> pend_v_r)
    else $error("sweep writes a cell that was not read");

  a_end_after_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(bwd_r))
    else $error("sweep ended before the backward pass");

endmodule
`default_nettype wire

@@ hdl/chamfer_humidity_spread_unit.sv @@
// Top level of the chamfer humidity spread unit: stream ports, register port and grid memory.
// A write word is stored in the grid memory at the same edge at which it is accepted.
// A read word moves the block to a read state; its result is registered once no earlier one still waits.
// A run word occupies the block for both passes: each cell costs two
// reads on the single grid read port per pass, plus one setup and one drain state per row.
// Reset clears control state and restores the registers; the grid memory is not cleared.
`default_nettype none
module chamfer_humidity_spread_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: cell_index [15:0], humidity_in [31:16]
  input  wire logic [31:0] in_tdata,
  // in_tuser: operation [1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: humidity_out [15:0], index_echo [31:16]
  output logic [31:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN  = 2'd1;
  localparam logic [1:0] T_RD   = 2'd2;

  logic [1:0]                         state_r, state_nxt;
  logic [chs_pkg::SIZE_W-1:0]         cfg_w_r, cfg_h_r;
  logic [chs_pkg::VAL_W-1:0]          cfg_s_r, cfg_d_r;
  logic                               out_valid_r, out_valid_nxt;
  logic [chs_pkg::VAL_W-1:0]          out_hum_r, out_hum_nxt;
  logic [15:0]                        out_idx_r, out_idx_nxt;
  logic [15:0]                        rd_idx_r, rd_idx_nxt;
  logic                               rd_ok_r, rd_ok_nxt;

  chs_pkg::chs_geom_t                 geom;
  chs_pkg::chs_mem_req_t              host_req, sweep_req, ram_req;
  logic                               sweep_busy;
  logic                               start;
  logic [chs_pkg::VAL_W-1:0]          rdata;
  logic                               accept;
  logic                               cfg_wr;
  logic [1:0]                         op;
  logic [15:0]                        idx;
  logic [chs_pkg::VAL_W-1:0]          hum, hum_cl;
  logic                               in_range;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= chs_pkg::RST_WIDTH;
      cfg_h_r <= chs_pkg::RST_HEIGHT;
      cfg_s_r <= chs_pkg::RST_STRAIGHT;
      cfg_d_r <= chs_pkg::RST_DIAGONAL;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        chs_pkg::REG_WIDTH:    cfg_w_r <= cfg_pwdata[chs_pkg::SIZE_W-1:0];
        chs_pkg::REG_HEIGHT:   cfg_h_r <= cfg_pwdata[chs_pkg::SIZE_W-1:0];
        chs_pkg::REG_STRAIGHT: cfg_s_r <= cfg_pwdata[chs_pkg::VAL_W-1:0];
        chs_pkg::REG_DIAGONAL: cfg_d_r <= cfg_pwdata[chs_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      chs_pkg::REG_WIDTH:    cfg_prdata = 32'(cfg_w_r);
      chs_pkg::REG_HEIGHT:   cfg_prdata = 32'(cfg_h_r);
      chs_pkg::REG_STRAIGHT: cfg_prdata = 32'(cfg_s_r);
      chs_pkg::REG_DIAGONAL: cfg_prdata = 32'(cfg_d_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign geom.w      = chs_pkg::clamp_dim(cfg_w_r, chs_pkg::MAX_WIDTH);
  assign geom.h      = chs_pkg::clamp_dim(cfg_h_r, chs_pkg::MAX_HEIGHT);
  assign geom.cells  = chs_pkg::CNT_W'(geom.w) * chs_pkg::CNT_W'(geom.h);
  assign geom.s_drop = cfg_s_r;
  assign geom.d_drop = cfg_d_r;

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign op        = in_tuser;
  assign idx       = in_tdata[15:0];
  assign hum       = in_tdata[31:16];
  assign hum_cl    = (hum > chs_pkg::ONE_Q15) ? chs_pkg::ONE_Q15 : hum;
  assign in_range  = (32'(idx) < 32'(geom.cells));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_hum_nxt   = out_hum_r;
    out_idx_nxt   = out_idx_r;
    rd_idx_nxt    = rd_idx_r;
    rd_ok_nxt     = rd_ok_r;
    host_req      = '0;
    start         = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          case (op)
            chs_pkg::OP_WRITE: begin
              host_req.we    = in_range;
              host_req.waddr = chs_pkg::ADDR_W'(idx);
              host_req.wdata = hum_cl;
            end
            chs_pkg::OP_RUN: begin
              start     = 1'b1;
              state_nxt = T_RUN;
            end
            chs_pkg::OP_READ: begin
              host_req.re    = 1'b1;
              host_req.raddr = chs_pkg::ADDR_W'(idx);
              rd_idx_nxt     = idx;
              rd_ok_nxt      = in_range;
              state_nxt      = T_RD;
            end
            default: ;
          endcase
        end
      end
      T_RUN: begin
        if (!sweep_busy) begin
          state_nxt = T_IDLE;
        end
      end
      T_RD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_hum_nxt   = rd_ok_r ? rdata : '0;
          out_idx_nxt   = rd_idx_r;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hum_r <= out_hum_nxt;
    out_idx_r <= out_idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_ok_r   <= rd_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_idx_r, out_hum_r};

  assign ram_req = sweep_busy ? sweep_req : host_req;

  chs_sweep u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .geom  (geom),
    .rdata (rdata),
    .req   (sweep_req),
    .busy  (sweep_busy)
  );

  chs_ram #(
    .WIDTH (chs_pkg::VAL_W),
    .DEPTH (chs_pkg::CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !sweep_busy)
    else $error("word accepted while a pass is running");

  a_load_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == T_RD))
    else $error("result word loaded without a read");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> sweep_busy)
    else $error("run did not start the sweep");

endmodule
`default_nettype wire

@@ bench/chamfer_humidity_spread_unit_test.sv @@
// Self-checking bench of the chamfer humidity spread unit: table-driven and random words.
module chamfer_humidity_spread_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int RANDOM_WORDS = 1550;
  localparam int DIRECTED_ROWS = 32;

  typedef enum logic [0:0] {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  code;
    logic [15:0] idx;
    logic [31:0] val;
    bit          typed;
    logic [15:0] want;
  } stim_row_t;

  typedef struct {
    logic [15:0] humidity;
    logic [15:0] index;
  } read_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [15:0] grid_model [0:65535];
  bit          cell_written [0:65535];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [15:0] straight_drop;
  logic [15:0] diagonal_drop;

  read_word_t  pending_reads [$];
  int          failures = 0;
  int          burst_left = 0;
  int          random_words = 0;
  bit          settled = 1'b1;

  logic [7:0]  ready_mask = 8'hFF;
  logic [15:0] ready_tick = '0;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_WORD, chs_pkg::OP_READ,      16'd4096,  32'd0,     1'b1, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd65535, 32'd0,     1'b1, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd0,     32'hFFFF,  1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd0,     32'd0,     1'b1, 16'd32768},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd4096,  32'd1234,  1'b0, 16'd0},
    '{ROW_WORD, OP_NONE,               16'd5,     32'd77,    1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd4095,  32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd4095,  32'd0,     1'b1, 16'd0},
    '{ROW_REG,  chs_pkg::REG_WIDTH,    16'd0,     32'd3,     1'b0, 16'd0},
    '{ROW_REG,  chs_pkg::REG_HEIGHT,   16'd0,     32'd2,     1'b0, 16'd0},
    '{ROW_REG,  chs_pkg::REG_STRAIGHT, 16'd0,     32'd3277,  1'b0, 16'd0},
    '{ROW_REG,  chs_pkg::REG_DIAGONAL, 16'd0,     32'd4634,  1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd0,     32'd32768, 1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd1,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd2,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd3,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd4,     32'd100,   1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd5,     32'd20000, 1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_RUN,       16'd0,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd2,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd3,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd5,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd6,     32'd0,     1'b1, 16'd0},
    '{ROW_REG,  chs_pkg::REG_STRAIGHT, 16'd0,     32'd32768, 1'b0, 16'd0},
    '{ROW_REG,  chs_pkg::REG_DIAGONAL, 16'd0,     32'hFFFF,  1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_WRITE,     16'd4,     32'd1,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_RUN,       16'd0,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd4,     32'd0,     1'b1, 16'd1},
    '{ROW_REG,  chs_pkg::REG_WIDTH,    16'd0,     32'd0,     1'b0, 16'd0},
    '{ROW_REG,  chs_pkg::REG_HEIGHT,   16'd0,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd0,     32'd0,     1'b0, 16'd0},
    '{ROW_WORD, chs_pkg::OP_READ,      16'd1,     32'd0,     1'b1, 16'd0}
  };

  chamfer_humidity_spread_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int dim_in_use(logic [8:0] v, int hi);
    if (v == 9'd0) begin
      return 1;
    end
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  function automatic int grid_cells();
    return dim_in_use(width_reg, chs_pkg::MAX_WIDTH) *
           dim_in_use(height_reg, chs_pkg::MAX_HEIGHT);
  endfunction

  function automatic logic [15:0] less_dropoff(logic [15:0] v, logic [15:0] drop);
    return (v > drop) ? v - drop : 16'd0;
  endfunction

  function automatic logic [15:0] larger(logic [15:0] a, logic [15:0] b);
    return (b > a) ? b : a;
  endfunction

  function automatic void spread_humidity();
    int w;
    int h;
    int x;
    int y;
    int at;
    logic [15:0] best;
    w = dim_in_use(width_reg, chs_pkg::MAX_WIDTH);
    h = dim_in_use(height_reg, chs_pkg::MAX_HEIGHT);
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        at = y * w + x;
        best = grid_model[at];
        if (x > 0) best = larger(best, less_dropoff(grid_model[at - 1], straight_drop));
        if (y > 0) best = larger(best, less_dropoff(grid_model[at - w], straight_drop));
        if (x > 0 && y > 0)
          best = larger(best, less_dropoff(grid_model[at - w - 1], diagonal_drop));
        if (x + 1 < w && y > 0)
          best = larger(best, less_dropoff(grid_model[at - w + 1], diagonal_drop));
        grid_model[at] = best;
      end
    end
    for (y = h - 1; y >= 0; y--) begin
      for (x = w - 1; x >= 0; x--) begin
        at = y * w + x;
        best = grid_model[at];
        if (x + 1 < w) best = larger(best, less_dropoff(grid_model[at + 1], straight_drop));
        if (y + 1 < h) best = larger(best, less_dropoff(grid_model[at + w], straight_drop));
        if (x + 1 < w && y + 1 < h)
          best = larger(best, less_dropoff(grid_model[at + w + 1], diagonal_drop));
        if (x > 0 && y + 1 < h)
          best = larger(best, less_dropoff(grid_model[at + w - 1], diagonal_drop));
        grid_model[at] = best;
      end
    end
  endfunction

  function automatic logic [15:0] humidity_sample();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) return 16'd0;
    if (pick < 10) return chs_pkg::ONE_Q15;
    if (pick < 11) return 16'($urandom());
    return 16'($urandom_range(0, 32768));
  endfunction

  function automatic logic [15:0] dropoff_sample();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return chs_pkg::ONE_Q15;
      2: return 16'hFFFF;
      3: return 16'($urandom());
      default: return 16'($urandom_range(0, 6000));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    failures++;
  endtask

  task automatic push_word(logic [1:0] op, logic [15:0] idx, logic [15:0] hum,
                           bit typed = 1'b0, logic [15:0] want = 16'd0);
    int gap;
    read_word_t rd;
    if (cfg_psel) begin
      cfg_psel <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {hum, idx};
    do @(posedge clk); while (!in_tready);
    settled = 1'b0;
    case (op)
      chs_pkg::OP_WRITE: begin
        if (int'(idx) < grid_cells()) begin
          grid_model[idx] = (hum > chs_pkg::ONE_Q15) ? chs_pkg::ONE_Q15 : hum;
          cell_written[idx] = 1'b1;
        end
      end
      chs_pkg::OP_RUN: spread_humidity();
      chs_pkg::OP_READ: begin
        rd.index = idx;
        rd.humidity = (int'(idx) < grid_cells()) ? grid_model[idx] : 16'd0;
        if (typed) rd.humidity = want;
        pending_reads = {pending_reads, rd};
      end
      default: ;
    endcase
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (4 * grid_cells() + 4 * dim_in_use(height_reg, chs_pkg::MAX_HEIGHT) + 8)
      @(posedge clk);
    settled = 1'b1;
  endtask

  task automatic apb_write(logic [1:0] reg_code, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_code, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (reg_code)
      chs_pkg::REG_WIDTH: width_reg = value[8:0];
      chs_pkg::REG_HEIGHT: height_reg = value[8:0];
      chs_pkg::REG_STRAIGHT: straight_drop = value[15:0];
      default: diagonal_drop = value[15:0];
    endcase
  endtask

  task automatic random_phase();
    int geo_w;
    int geo_h;
    int cells;
    int steps;
    int pick;
    int i;
    case ($urandom_range(0, 9))
      0: begin
        geo_w = $urandom_range(0, 1) ? 256 : 511;
        geo_h = $urandom_range(0, 1);
      end
      1: begin
        geo_w = $urandom_range(0, 1);
        geo_h = $urandom_range(0, 1) ? 256 : 511;
      end
      2: begin
        geo_w = $urandom_range(0, 2);
        geo_h = $urandom_range(0, 2);
      end
      default: begin
        geo_w = $urandom_range(1, 16);
        geo_h = $urandom_range(1, 16);
        if (geo_w * geo_h > 160) geo_h = 160 / geo_w;
      end
    endcase
    wait_idle();
    apb_write(chs_pkg::REG_WIDTH, 32'(geo_w));
    apb_write(chs_pkg::REG_HEIGHT, 32'(geo_h));
    apb_write(chs_pkg::REG_STRAIGHT, 32'(dropoff_sample()));
    apb_write(chs_pkg::REG_DIAGONAL, 32'(dropoff_sample()));
    cells = grid_cells();
    for (i = 0; i < cells; i++) begin
      if (!cell_written[i]) begin
        push_word(chs_pkg::OP_WRITE, 16'(i), humidity_sample());
        random_words++;
      end
    end
    push_word(chs_pkg::OP_RUN, 16'($urandom()), 16'($urandom()));
    random_words++;
    steps = $urandom_range(20, 80);
    for (i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        push_word(chs_pkg::OP_WRITE, 16'($urandom_range(0, cells - 1)), humidity_sample());
        random_words++;
      end else if (pick < 75) begin
        push_word(chs_pkg::OP_READ, 16'($urandom_range(0, cells - 1)), 16'($urandom()));
        random_words++;
      end else if (pick < 83) begin
        push_word(chs_pkg::OP_READ, 16'($urandom_range(cells, 65535)), 16'($urandom()));
        random_words++;
      end else if (pick < 88) begin
        push_word(chs_pkg::OP_WRITE, 16'($urandom_range(cells, 65535)), 16'($urandom()));
        random_words++;
      end else if (pick < 92) begin
        push_word(OP_NONE, 16'($urandom()), 16'($urandom()));
        random_words++;
      end else begin
        push_word(chs_pkg::OP_RUN, 16'($urandom()), 16'($urandom()));
        random_words++;
      end
    end
  endtask

  always @(posedge clk) begin
    ready_tick <= ready_tick + 16'd1;
    if (ready_tick[6:0] == 7'd0) begin
      case ($urandom_range(0, 3))
        0: ready_mask <= 8'hFF;
        1: ready_mask <= 8'($urandom());
        2: ready_mask <= 8'h01 << $urandom_range(0, 7);
        default: ready_mask <= 8'hAA;
      endcase
    end
    out_tready <= ready_mask[ready_tick[2:0]];
  end

  always @(posedge clk) begin
    read_word_t rd;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reads.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", out_tdata));
      end else begin
        rd = pending_reads.pop_front();
        if (out_tdata[15:0] !== rd.humidity)
          report_mismatch($sformatf("humidity_out %0d, want %0d (index %0d)",
                                    out_tdata[15:0], rd.humidity, rd.index));
        if (out_tdata[31:16] !== rd.index)
          report_mismatch($sformatf("index_echo %0d, want %0d",
                                    out_tdata[31:16], rd.index));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tvalid = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    width_reg = chs_pkg::RST_WIDTH;
    height_reg = chs_pkg::RST_HEIGHT;
    straight_drop = chs_pkg::RST_STRAIGHT;
    diagonal_drop = chs_pkg::RST_DIAGONAL;
    foreach (grid_model[i]) begin
      grid_model[i] = 16'd0;
      cell_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG) begin
        if (!settled) wait_idle();
        apb_write(directed_rows[r].code, directed_rows[r].val);
      end else begin
        push_word(directed_rows[r].code, directed_rows[r].idx, directed_rows[r].val[15:0],
                  directed_rows[r].typed, directed_rows[r].want);
      end
    end
    while (random_words < RANDOM_WORDS) random_phase();
    wait_idle();
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
